// ----- rtl/core/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and microcode for the integer to ASCII formatter
// Control word layout, opcode and jump condition codes, the program ROM
// contents and the character constants used by the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    // Value and digit storage widths
    localparam int VALUE_W = 32;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = DIGITS * 4;
    localparam int CHAR_W  = 7;

    typedef logic [3:0] upc_t;
    typedef logic [3:0] dig_idx_t;
    typedef logic [4:0] bit_cnt_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Characters
    localparam char_t CHR_ZERO     = 7'h30;
    localparam char_t CHR_X        = 7'h78;
    localparam char_t CHR_MINUS    = 7'h2D;
    localparam char_t CHR_HEX_BASE = 7'h37;  // 'A' - 10

    // Start index of the most significant digit in each mode
    localparam dig_idx_t DEC_TOP = 4'd9;
    localparam dig_idx_t HEX_TOP = 4'd7;
    localparam bit_cnt_t DABBLE_LAST = 5'd31;

    // Datapath operations
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DABBLE,
        OP_SIGN,
        OP_LIT,
        OP_SKIP,
        OP_DIGIT
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_NO_BEAT,
        C_HEX,
        C_CNT_NZ,
        C_LEAD,
        C_IDX_NZ
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        upc_t  target;
        char_t lit;
    } ctrl_t;

    // Status from datapath to sequencer
    typedef struct packed {
        logic in_beat;
        logic hex;
        logic cnt_nz;
        logic lead;
        logic idx_nz;
        logic hold;
    } dp_flags_t;

    // Program step labels
    localparam upc_t STEP_IDLE   = 4'd0;
    localparam upc_t STEP_MODE   = 4'd1;
    localparam upc_t STEP_DABBLE = 4'd2;
    localparam upc_t STEP_SIGN   = 4'd3;
    localparam upc_t STEP_PFX0   = 4'd4;
    localparam upc_t STEP_PFXX   = 4'd5;
    localparam upc_t STEP_SKIP   = 4'd6;
    localparam upc_t STEP_DIGIT  = 4'd7;
    localparam upc_t STEP_DONE   = 4'd8;

    // Program ROM
    function automatic ctrl_t urom_word(input upc_t pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: STEP_IDLE, lit: CHR_ZERO};
        case (pc)
            STEP_IDLE:   w = '{OP_LOAD,   C_NO_BEAT, STEP_IDLE,   CHR_ZERO};
            STEP_MODE:   w = '{OP_NOP,    C_HEX,     STEP_PFX0,   CHR_ZERO};
            STEP_DABBLE: w = '{OP_DABBLE, C_CNT_NZ,  STEP_DABBLE, CHR_ZERO};
            STEP_SIGN:   w = '{OP_SIGN,   C_ALWAYS,  STEP_SKIP,   CHR_MINUS};
            STEP_PFX0:   w = '{OP_LIT,    C_NONE,    STEP_IDLE,   CHR_ZERO};
            STEP_PFXX:   w = '{OP_LIT,    C_NONE,    STEP_IDLE,   CHR_X};
            STEP_SKIP:   w = '{OP_SKIP,   C_LEAD,    STEP_SKIP,   CHR_ZERO};
            STEP_DIGIT:  w = '{OP_DIGIT,  C_IDX_NZ,  STEP_DIGIT,  CHR_ZERO};
            STEP_DONE:   w = '{OP_NOP,    C_ALWAYS,  STEP_IDLE,   CHR_ZERO};
            default:     w = '{OP_NOP,    C_ALWAYS,  STEP_IDLE,   CHR_ZERO};
        endcase
        return w;
    endfunction

    // Digit value to ASCII, upper-case hex
    function automatic char_t digit_char(input logic [3:0] d);
        char_t c;
        if (d < 4'd10) begin
            c = CHR_ZERO + {3'b000, d};
        end else begin
            c = CHR_HEX_BASE + {3'b000, d};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/i2a_urom.sv -----
// ----------------------------------------------------------------------------
// i2a_urom: microprogram store
// Read-only table of control words, one per program step.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_urom
    import i2a_pkg::*;
(
    input  var upc_t  upc,
    output var ctrl_t ctrl
);

    // Look up the control word for the current step
    always_comb begin
        ctrl = urom_word(upc);
    end

endmodule

`default_nettype wire

// ----- rtl/core/i2a_dpath.sv -----
// ----------------------------------------------------------------------------
// i2a_dpath: formatter datapath
// Holds the operand, the digit register, the loop and digit counters and the
// output beat register; executes one control word per cycle unless held.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_dpath
    import i2a_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,
    input  var  ctrl_t       ctrl,
    output var  dp_flags_t   flags,
    input  wire              s_valid,
    output wire              s_ready,
    input  wire              s_action,
    input  wire [VALUE_W-1:0] s_value,
    output wire              m_valid,
    input  wire              m_ready,
    output wire [CHAR_W-1:0] m_character,
    output wire              m_last
);

    logic [VALUE_W-1:0] bin_reg,  bin_next;
    logic [BCD_W-1:0]   bcd_reg,  bcd_next;
    bit_cnt_t           cnt_reg,  cnt_next;
    dig_idx_t           idx_reg,  idx_next;
    logic               hex_reg,  hex_next;
    logic               neg_reg,  neg_next;
    logic               m_valid_reg, m_valid_next;
    char_t              m_char_reg,  m_char_next;
    logic               m_last_reg,  m_last_next;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         cur_digit;
    logic               in_beat;
    logic               out_free;
    logic               emit;
    logic               fire;
    char_t              emit_char;
    logic [VALUE_W-1:0] magnitude;

    // Accept a beat only in the load step and never while reset is held
    assign s_ready  = (ctrl.op == OP_LOAD) && aresetn;
    assign in_beat  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Two's complement magnitude, wraps for the most negative value
    assign magnitude = s_value[VALUE_W-1] ? (~s_value + 1'b1) : s_value;

    assign cur_digit = bcd_reg[idx_reg*4 +: 4];

    // Add 3 to each BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // Select the character for this step
    always_comb begin
        emit      = 1'b0;
        emit_char = ctrl.lit;
        case (ctrl.op)
            OP_LIT: begin
                emit = 1'b1;
            end
            OP_SIGN: begin
                emit      = neg_reg;
                emit_char = CHR_MINUS;
            end
            OP_DIGIT: begin
                emit      = 1'b1;
                emit_char = digit_char(cur_digit);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign fire = emit && out_free;

    // Status back to the sequencer
    always_comb begin
        flags.in_beat = in_beat;
        flags.hex     = hex_reg;
        flags.cnt_nz  = (cnt_reg != '0);
        flags.lead    = (cur_digit == 4'd0) && (idx_reg != '0);
        flags.idx_nz  = (idx_reg != '0);
        flags.hold    = emit && !out_free;
    end

    // Operand, digit and counter updates
    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        hex_next = hex_reg;
        neg_next = neg_reg;
        case (ctrl.op)
            OP_LOAD: begin
                if (in_beat) begin
                    hex_next = s_action;
                    cnt_next = DABBLE_LAST;
                    if (s_action) begin
                        bin_next = s_value;
                        bcd_next = {{(BCD_W-VALUE_W){1'b0}}, s_value};
                        idx_next = HEX_TOP;
                        neg_next = 1'b0;
                    end else begin
                        bin_next = magnitude;
                        bcd_next = '0;
                        idx_next = DEC_TOP;
                        neg_next = s_value[VALUE_W-1];
                    end
                end
            end
            OP_DABBLE: begin
                bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_SKIP: begin
                if (flags.lead) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            OP_DIGIT: begin
                if (fire && (idx_reg != '0)) begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default: begin
                bin_next = bin_reg;
            end
        endcase
    end

    // Output beat register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        if (fire) begin
            m_valid_next = 1'b1;
            m_char_next  = emit_char;
            m_last_next  = (ctrl.op == OP_DIGIT) && (idx_reg == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        idx_reg    <= idx_next;
        hex_reg    <= hex_next;
        neg_reg    <= neg_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_char_reg;
    assign m_last      = m_last_reg;

endmodule

`default_nettype wire

// ----- rtl/core/integer_to_ascii_formatter_top.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: microcoded integer to ASCII formatter
// Formats a 32-bit value as signed decimal or as 0x-prefixed upper-case hex
// and sends it out one character per beat, the final character flagged.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_action[0:0], s_value[31:0]
//   m_       out        m_valid/m_ready    m_character[6:0], m_last
//
// One number at a time. Decimal runs the 32 double-dabble steps, the sign
// step, the leading-zero skip loop and the digit loop; hex runs the prefix
// steps, the skip loop and the digit loop. Reset clears the step counter
// and the output beat register only; s_ready stays low while reset is
// held.
// An emit step holds while the output beat register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_top
    import i2a_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output wire               s_ready,
    input  wire               s_action,
    input  wire [VALUE_W-1:0] s_value,
    output wire               m_valid,
    input  wire               m_ready,
    output wire [CHAR_W-1:0]  m_character,
    output wire               m_last
);

    upc_t      upc_reg, upc_next;
    ctrl_t     ctrl;
    dp_flags_t flags;
    logic      take_jump;

    i2a_urom u_urom (
        .upc  (upc_reg),
        .ctrl (ctrl)
    );

    i2a_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .flags       (flags),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    // Evaluate the jump condition
    always_comb begin
        case (ctrl.cond)
            C_NONE:    take_jump = 1'b0;
            C_ALWAYS:  take_jump = 1'b1;
            C_NO_BEAT: take_jump = !flags.in_beat;
            C_HEX:     take_jump = flags.hex;
            C_CNT_NZ:  take_jump = flags.cnt_nz;
            C_LEAD:    take_jump = flags.lead;
            C_IDX_NZ:  take_jump = flags.idx_nz;
            default:   take_jump = 1'b0;
        endcase
    end

    // Hold, jump or advance the step counter
    always_comb begin
        if (flags.hold) begin
            upc_next = upc_reg;
        end else if (take_jump) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = upc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: integer to ASCII formatter
// Sends signed decimal and hex numbers through the formatter, predicts the
// character string for each accepted number and checks every output beat,
// character and final flag, in order. The sender works in bursts and the
// receiver stalls on changing patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
    import i2a_pkg::*;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_ITEMS = 410;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  REPORT_MAX   = 10;
    localparam bit  MODE_DEC     = 1'b0;
    localparam bit  MODE_HEX     = 1'b1;
    localparam char_t CHAR_UPPER_A = 7'h41;

    typedef struct {
        char_t ch;
        logic  is_last;
    } char_beat_t;

    // Expected character beats, oldest first
    class char_scoreboard;
        char_beat_t awaited[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_number(bit hex_mode, logic [VALUE_W-1:0] number);
            logic [VALUE_W-1:0] mag;
            char_t              text[$];
            char_t              digs[$];
            logic [3:0]         nib;
            char_beat_t         beat;
            mag = number;
            if (hex_mode == MODE_DEC) begin
                // sign first, then the magnitude modulo 2^32
                if (number[VALUE_W-1]) begin
                    text.push_back(CHR_MINUS);
                    mag = 32'd0 - number;
                end
                do begin
                    digs.push_front(CHR_ZERO + char_t'(mag % 10));
                    mag = mag / 10;
                end while (mag != 0);
            end else begin
                text.push_back(CHR_ZERO);
                text.push_back(CHR_X);
                do begin
                    nib = mag[3:0];
                    if (nib < 4'd10) begin
                        digs.push_front(CHR_ZERO + char_t'(nib));
                    end else begin
                        digs.push_front(CHAR_UPPER_A + char_t'(nib - 4'd10));
                    end
                    mag = mag >> 4;
                end while (mag != 0);
            end
            foreach (digs[i]) text.push_back(digs[i]);
            foreach (text[i]) begin
                beat.ch      = text[i];
                beat.is_last = (i == text.size() - 1);
                awaited.push_back(beat);
            end
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= REPORT_MAX) $display("ERROR: %s", msg);
        endfunction

        function void check_char(char_t ch, logic is_last);
            char_beat_t want;
            if (awaited.size() == 0) begin
                flag_error($sformatf("unexpected beat: character %02h last %0b", ch, is_last));
                return;
            end
            want = awaited.pop_front();
            if (ch !== want.ch) begin
                flag_error($sformatf("character: expected %02h got %02h", want.ch, ch));
            end
            if (is_last !== want.is_last) begin
                flag_error($sformatf("last on %02h: expected %0b got %0b",
                                     want.ch, want.is_last, is_last));
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    wire                s_ready;
    logic               s_action;
    logic [VALUE_W-1:0] s_value;
    wire                m_valid;
    logic               m_ready;
    wire  [CHAR_W-1:0]  m_character;
    wire                m_last;

    char_scoreboard sb = new();
    int             cycles = 0;
    int             hold_requests = 0;
    int             burst_left = 0;

    integer_to_ascii_formatter_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Watch both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_number(s_action, s_value);
            if (m_valid && m_ready) sb.check_char(m_character, m_last);
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off on request
    initial begin : receiver
        int  holds_seen;
        int  stall_left;
        int  pattern;
        int  pattern_left;
        logic [7:0] mask;
        holds_seen   = 0;
        stall_left   = 0;
        pattern      = 0;
        pattern_left = 0;
        mask         = 8'b1011_0110;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern      = $urandom_range(0, 2);
                    pattern_left = $urandom_range(20, 200);
                end
                pattern_left--;
                case (pattern)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = ($urandom_range(0, 1) == 1);
                    end
                    default: begin
                        mask    = {mask[6:0], mask[7]};
                        m_ready = mask[0];
                    end
                endcase
            end
        end
    end

    // Offer one number and hold it until accepted; return at the next falling edge
    task automatic send_number(input bit hex_mode, input logic [VALUE_W-1:0] number);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_valid  = 1'b1;
        s_action = hex_mode;
        s_value  = number;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Pause the sender until every expected beat has come out
    task automatic wait_drained();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        logic [VALUE_W-1:0] decade;
        int k;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(0, 31);
            2: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
            3: begin
                // around a power of ten
                decade = 32'd1;
                k = $urandom_range(0, 9);
                repeat (k) decade = decade * 10;
                v = decade - $urandom_range(0, 1);
            end
            4: begin
                // around a power of sixteen
                v = (32'd1 << (4 * $urandom_range(0, 7))) - $urandom_range(0, 1);
            end
            default: v = {$urandom_range(0, 1) == 1, 31'd0} ^ $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    initial begin : stimulus
        logic [VALUE_W-1:0] dir_values[20];
        bit                 dir_modes[20];
        int                 n;
        aresetn  = 1'b0;
        s_valid  = 1'b0;
        s_action = 1'b0;
        s_value  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: zero, extremes, digit boundaries in both modes
        dir_values = '{32'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                       32'd9, 32'd10, 32'd1_000_000_000, 32'hFFFF_FFF6, 32'd4_000_000_000,
                       32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_000F, 32'h0000_0010,
                       32'hABCD_EF01, 32'h1234_5678, 32'h0000_0001, 32'h5A5A_A5A5,
                       32'd999_999_999, 32'h0F0F_0F0F};
        dir_modes  = '{MODE_DEC, MODE_HEX, MODE_DEC, MODE_DEC, MODE_DEC,
                       MODE_DEC, MODE_DEC, MODE_DEC, MODE_DEC, MODE_DEC,
                       MODE_HEX, MODE_HEX, MODE_HEX, MODE_HEX,
                       MODE_HEX, MODE_HEX, MODE_DEC, MODE_HEX,
                       MODE_DEC, MODE_HEX};
        foreach (dir_values[i]) send_number(dir_modes[i], dir_values[i]);
        wait_drained();

        // Random numbers; one long receiver hold-off and one full drain midway
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 120) hold_requests++;
            if (n == 260) wait_drained();
            send_number($urandom_range(0, 1) == 1, pick_value());
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
